[design/fm_quadrature_demodulator_core_macros.svh]
// ----------------------------------------------------------------------------
// FM quadrature demodulator - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FM_QUADRATURE_DEMODULATOR_CORE_MACROS_SVH
`define FM_QUADRATURE_DEMODULATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FQD_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FQD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fqd_pkg.sv]
// ----------------------------------------------------------------------------
// fqd_pkg
// Constants, command/status types and CORDIC angle table for the demodulator.
// ----------------------------------------------------------------------------
package fqd_pkg;

   localparam int CORDIC_STAGES   = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int STAGE_W         = $clog2(CORDIC_STAGES);
   localparam int ATAN_ENTRIES    = 24;
   localparam int ATAN_IDX_W      = 5;

   localparam int SAMPLE_W   = 16;
   localparam int FREQ_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // arctangent of 2^-i, 2^32 per turn
   localparam logic [29:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
      30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162,
      30'd81
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PHASE_STEP  = 3'd0,
      REG_COEF_B0     = 3'd1,
      REG_COEF_B1     = 3'd2,
      REG_COEF_A1     = 3'd3,
      REG_COEF_A2     = 3'd4,
      REG_CENTER_FREQ = 3'd5,
      REG_FREQ_SCALE  = 3'd6
   } csr_reg_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_SMP_C,
      MUL_SMP_S,
      MUL_B0X,
      MUL_B1X,
      MUL_A1Y,
      MUL_A2Y,
      MUL_IPI,
      MUL_QPQ,
      MUL_QPI,
      MUL_IPQ,
      MUL_FREQ
   } mul_op_type;

   typedef enum logic [4:0] {
      ALU_NONE,
      ALU_LOAD,
      ALU_NCO,
      ALU_TAKE_XI,
      ALU_TAKE_XQ,
      ALU_F_M0,
      ALU_F_M1Y,
      ALU_F_M2,
      ALU_F_DLY,
      ALU_DX0,
      ALU_DX1,
      ALU_DY0,
      ALU_DY1,
      ALU_NORM,
      ALU_VINIT,
      ALU_VEC,
      ALU_FREQ,
      ALU_OUT
   } alu_op_type;

   typedef struct packed {
      mul_op_type               mul_op;
      alu_op_type               alu_op;
      logic                     ch;
      logic [STAGE_W-1:0]       stage;
   } dp_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic norm_zero;
      logic norm_ok;
   } dp_stat_type;

   function automatic logic [29:0] atan_at(input logic [STAGE_W-1:0] idx);
      return ATAN_TURNS[ATAN_IDX_W'(idx)];
   endfunction

endpackage

[design/fqd_intf.sv]
// ----------------------------------------------------------------------------
// fqd channel interfaces
// Sample input, frequency result and register write channels.
// ----------------------------------------------------------------------------
interface fqd_req_if import fqd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface fqd_rsp_if import fqd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [FREQ_W-1:0] frequency;
   logic                     valid_res;
   modport source (output valid, output frequency, output valid_res, input ready);
   modport sink   (input valid, input frequency, input valid_res, output ready);
endinterface

interface fqd_csr_if import fqd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/fqd_ctrl.sv]
// ----------------------------------------------------------------------------
// fqd_ctrl
// Sequencer: steps the shared multiplier and CORDIC through one sample.
// ----------------------------------------------------------------------------
module fqd_ctrl import fqd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [21:0] {
      S_IDLE  = 22'd1 << 0,
      S_NCO   = 22'd1 << 1,
      S_MX1   = 22'd1 << 2,
      S_MX2   = 22'd1 << 3,
      S_MX3   = 22'd1 << 4,
      S_F1    = 22'd1 << 5,
      S_F2    = 22'd1 << 6,
      S_F3    = 22'd1 << 7,
      S_F4    = 22'd1 << 8,
      S_F5    = 22'd1 << 9,
      S_F6    = 22'd1 << 10,
      S_D1    = 22'd1 << 11,
      S_D2    = 22'd1 << 12,
      S_D3    = 22'd1 << 13,
      S_D4    = 22'd1 << 14,
      S_D5    = 22'd1 << 15,
      S_NORM  = 22'd1 << 16,
      S_VINIT = 22'd1 << 17,
      S_VEC   = 22'd1 << 18,
      S_FQ1   = 22'd1 << 19,
      S_FQ2   = 22'd1 << 20,
      S_OUT   = 22'd1 << 21
   } state_type;

   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);

   state_type          state_ff, state_in;
   logic [STAGE_W-1:0] cnt_ff, cnt_in;
   logic               ch_ff, ch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ch_in      = ch_ff;
      cmd.mul_op = MUL_NONE;
      cmd.alu_op = ALU_NONE;
      cmd.ch     = ch_ff;
      cmd.stage  = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.alu_op = ALU_LOAD;
               cnt_in     = '0;
               state_in   = S_NCO;
            end
         end
         S_NCO: begin
            cmd.alu_op = ALU_NCO;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STAGE) begin
               state_in = S_MX1;
            end
         end
         S_MX1: begin
            cmd.mul_op = MUL_SMP_C;
            state_in   = S_MX2;
         end
         S_MX2: begin
            cmd.alu_op = ALU_TAKE_XI;
            cmd.mul_op = MUL_SMP_S;
            state_in   = S_MX3;
         end
         S_MX3: begin
            cmd.alu_op = ALU_TAKE_XQ;
            ch_in      = 1'b0;
            state_in   = S_F1;
         end
         S_F1: begin
            cmd.mul_op = MUL_B0X;
            state_in   = S_F2;
         end
         S_F2: begin
            cmd.alu_op = ALU_F_M0;
            cmd.mul_op = MUL_B1X;
            state_in   = S_F3;
         end
         S_F3: begin
            cmd.alu_op = ALU_F_M1Y;
            state_in   = S_F4;
         end
         S_F4: begin
            cmd.mul_op = MUL_A1Y;
            state_in   = S_F5;
         end
         S_F5: begin
            cmd.alu_op = ALU_F_M2;
            cmd.mul_op = MUL_A2Y;
            state_in   = S_F6;
         end
         S_F6: begin
            cmd.alu_op = ALU_F_DLY;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = S_F1;
            end else if (stat.have_prev) begin
               state_in = S_D1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_D1: begin
            cmd.mul_op = MUL_IPI;
            state_in   = S_D2;
         end
         S_D2: begin
            cmd.alu_op = ALU_DX0;
            cmd.mul_op = MUL_QPQ;
            state_in   = S_D3;
         end
         S_D3: begin
            cmd.alu_op = ALU_DX1;
            cmd.mul_op = MUL_QPI;
            state_in   = S_D4;
         end
         S_D4: begin
            cmd.alu_op = ALU_DY0;
            cmd.mul_op = MUL_IPQ;
            state_in   = S_D5;
         end
         S_D5: begin
            cmd.alu_op = ALU_DY1;
            state_in   = S_NORM;
         end
         S_NORM: begin
            // one shift per cycle until the larger magnitude sits in range, or both are zero
            cmd.alu_op = ALU_NORM;
            if (stat.norm_zero) begin
               state_in = S_FQ1;
            end else if (stat.norm_ok) begin
               state_in = S_VINIT;
            end
         end
         S_VINIT: begin
            cmd.alu_op = ALU_VINIT;
            cnt_in     = '0;
            state_in   = S_VEC;
         end
         S_VEC: begin
            cmd.alu_op = ALU_VEC;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STAGE) begin
               state_in = S_FQ1;
            end
         end
         S_FQ1: begin
            cmd.mul_op = MUL_FREQ;
            state_in   = S_FQ2;
         end
         S_FQ2: begin
            cmd.alu_op = ALU_FREQ;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               cmd.alu_op = ALU_OUT;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/fqd_dpath.sv]
// ----------------------------------------------------------------------------
// fqd_dpath
// Registers, oscillator, shared multiplier, biquads, discriminator, CORDIC.
// ----------------------------------------------------------------------------
module fqd_dpath import fqd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output logic signed [FREQ_W-1:0]   frequency,
   output logic                       valid_res
);

   localparam int DROP = 32 - SINE_TABLE_BITS;
   localparam logic [31:0]        PH_MASK  = ~((32'd1 << DROP) - 32'd1);
   localparam logic signed [33:0] X_GAIN   = 34'sd652032874;
   localparam logic signed [67:0] RND30    = 68'sd536870912;
   localparam logic signed [67:0] RND28    = 68'sd134217728;
   localparam logic signed [63:0] LIM30    = 64'sd1073741824;
   localparam logic signed [63:0] LIM29    = 64'sd536870912;
   localparam logic signed [33:0] HALF_TRN = 34'sd2147483648;

   // configuration
   logic [31:0]        phase_step_ff, phase_step_in;
   logic signed [31:0] b0_ff, b0_in, b1_ff, b1_in, a1_ff, a1_in, a2_ff, a2_in;
   logic [21:0]        center_ff, center_in;
   logic [17:0]        scale_ff, scale_in;

   // state carried between samples
   logic [31:0]        nco_phase_ff, nco_phase_in;
   logic signed [39:0] d0_ff [2], d0_in [2];
   logic signed [39:0] d1_ff [2], d1_in [2];
   logic               have_prev_ff, have_prev_in;
   logic signed [23:0] last_freq_ff, last_freq_in;

   // working registers
   logic signed [15:0] smp_ff, smp_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [31:0] xin_ff [2], xin_in [2];
   logic signed [31:0] cur_ff [2], cur_in [2];
   logic signed [31:0] prev_ff [2], prev_in [2];
   logic signed [34:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic signed [63:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [23:0] freq_out_ff, freq_out_in;
   logic               vres_ff, vres_in;

   logic signed [33:0] ma, mb, xneg, yneg, sx, sy, at;
   logic signed [15:0] c15, s15;
   logic signed [34:0] rnd_v;
   logic signed [63:0] half_p;
   logic signed [39:0] ft;
   logic [31:0]        ang_raw;
   logic               big, small_v, zero;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      if (v > 36'sd32767) return 16'sh7fff;
      if (v < -36'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
      if (v > 41'sd2147483647) return 32'sh7fffffff;
      if (v < -41'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
      if (v > 42'sd549755813887) return 40'sh7fffffffff;
      if (v < -42'sd549755813888) return 40'sh8000000000;
      return v[39:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
      if (v > 41'sd8388607) return 24'sh7fffff;
      if (v < -41'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic logic ge30(input logic signed [63:0] v);
      return (v >= LIM30) || (v <= -LIM30);
   endfunction

   function automatic logic lt29(input logic signed [63:0] v);
      return (v < LIM29) && (v > -LIM29);
   endfunction

   // oscillator outputs, rounded to Q1.15
   assign xneg = neg_ff ? -cx_ff : cx_ff;
   assign yneg = neg_ff ? -cy_ff : cy_ff;
   assign c15  = sat16((36'(xneg) + 36'sd16384) >>> 15);
   assign s15  = sat16((36'(yneg) + 36'sd16384) >>> 15);

   assign rnd_v  = 35'((prod_ff + RND30) >>> 30);
   assign half_p = $signed(prod_ff[64:1]);
   assign ft     = 40'((prod_ff + RND28) >>> 28);

   assign sx = cx_ff >>> cmd.stage;
   assign sy = cy_ff >>> cmd.stage;
   assign at = 34'(atan_at(cmd.stage));

   assign big     = ge30(dx_ff) || ge30(dy_ff);
   assign small_v = lt29(dx_ff) && lt29(dy_ff);
   assign zero    = (dx_ff == '0) && (dy_ff == '0);

   assign stat.have_prev = have_prev_ff;
   assign stat.norm_zero = zero;
   assign stat.norm_ok   = !big && !small_v;

   assign ang_raw = nco_phase_ff & PH_MASK;

   assign frequency = freq_out_ff;
   assign valid_res = vres_ff;

   // shared multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul_op)
         MUL_SMP_C: begin ma = 34'(smp_ff);     mb = 34'(c15);           end
         MUL_SMP_S: begin ma = 34'(smp_ff);     mb = 34'(s15);           end
         MUL_B0X:   begin ma = 34'(b0_ff);      mb = 34'(xin_ff[cmd.ch]); end
         MUL_B1X:   begin ma = 34'(b1_ff);      mb = 34'(xin_ff[cmd.ch]); end
         MUL_A1Y:   begin ma = 34'(a1_ff);      mb = 34'(cur_ff[cmd.ch]); end
         MUL_A2Y:   begin ma = 34'(a2_ff);      mb = 34'(cur_ff[cmd.ch]); end
         MUL_IPI:   begin ma = 34'(cur_ff[0]);  mb = 34'(prev_ff[0]);     end
         MUL_QPQ:   begin ma = 34'(cur_ff[1]);  mb = 34'(prev_ff[1]);     end
         MUL_QPI:   begin ma = 34'(cur_ff[1]);  mb = 34'(prev_ff[0]);     end
         MUL_IPQ:   begin ma = 34'(cur_ff[0]);  mb = 34'(prev_ff[1]);     end
         MUL_FREQ:  begin ma = cz_ff;           mb = $signed({16'd0, scale_ff}); end
         default:   begin ma = '0;              mb = '0;                  end
      endcase
   end

   assign prod_in = (cmd.mul_op == MUL_NONE) ? prod_ff : ma * mb;

   // configuration writes
   always_comb begin
      phase_step_in = phase_step_ff;
      b0_in         = b0_ff;
      b1_in         = b1_ff;
      a1_in         = a1_ff;
      a2_in         = a2_ff;
      center_in     = center_ff;
      scale_in      = scale_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_PHASE_STEP:  phase_step_in = csr_data;
            REG_COEF_B0:     b0_in         = $signed(csr_data);
            REG_COEF_B1:     b1_in         = $signed(csr_data);
            REG_COEF_A1:     a1_in         = $signed(csr_data);
            REG_COEF_A2:     a2_in         = $signed(csr_data);
            REG_CENTER_FREQ: center_in     = csr_data[21:0];
            REG_FREQ_SCALE:  scale_in      = csr_data[17:0];
            default:         ;
         endcase
      end
   end

   // datapath operations
   always_comb begin
      nco_phase_in = nco_phase_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      have_prev_in = have_prev_ff;
      last_freq_in = last_freq_ff;
      smp_in       = smp_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      xin_in       = xin_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      m0_in        = m0_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      freq_out_in  = freq_out_ff;
      vres_in      = vres_ff;
      case (cmd.alu_op)
         ALU_LOAD: begin
            // second and third quarters: turn by a half and negate at the end
            smp_in       = sample;
            neg_in       = ang_raw[31] ^ ang_raw[30];
            cz_in        = 34'($signed({ang_raw[31] ^ (ang_raw[31] ^ ang_raw[30]),
                                        ang_raw[30:0]}));
            cx_in        = X_GAIN;
            cy_in        = '0;
            nco_phase_in = nco_phase_ff + phase_step_ff;
         end
         ALU_NCO: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               cz_in = cz_ff + at;
            end
         end
         ALU_TAKE_XI: xin_in[0] = prod_ff[31:0];
         ALU_TAKE_XQ: xin_in[1] = 32'(-prod_ff);
         ALU_F_M0:    m0_in = rnd_v;
         ALU_F_M1Y: begin
            m1_in          = rnd_v;
            cur_in[cmd.ch] = sat32(41'(m0_ff) + 41'(d0_ff[cmd.ch]));
         end
         ALU_F_M2:    m2_in = rnd_v;
         ALU_F_DLY: begin
            d0_in[cmd.ch] = sat40(42'(m1_ff) - 42'(m2_ff) + 42'(d1_ff[cmd.ch]));
            d1_in[cmd.ch] = sat40(42'(m0_ff) - 42'(rnd_v));
         end
         ALU_DX0: dx_in = half_p;
         ALU_DX1: dx_in = dx_ff + half_p;
         ALU_DY0: dy_in = half_p;
         ALU_DY1: dy_in = dy_ff - half_p;
         ALU_NORM: begin
            if (zero) begin
               cz_in = '0;
            end else if (big) begin
               dx_in = dx_ff >>> 1;
               dy_in = dy_ff >>> 1;
            end else if (small_v) begin
               dx_in = dx_ff <<< 1;
               dy_in = dy_ff <<< 1;
            end
         end
         ALU_VINIT: begin
            // left half plane: fold over and start from a half turn
            if (dx_ff[63]) begin
               cx_in = 34'(-dx_ff);
               cy_in = 34'(-dy_ff);
               cz_in = dy_ff[63] ? -HALF_TRN : HALF_TRN;
            end else begin
               cx_in = 34'(dx_ff);
               cy_in = 34'(dy_ff);
               cz_in = '0;
            end
         end
         ALU_VEC: begin
            if (!cy_ff[33]) begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               cz_in = cz_ff + at;
            end else begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               cz_in = cz_ff - at;
            end
         end
         ALU_FREQ: last_freq_in = sat24(41'(ft) + 41'($signed({1'b0, center_ff})));
         ALU_OUT: begin
            freq_out_in  = last_freq_ff;
            vres_in      = have_prev_ff;
            prev_in      = cur_ff;
            have_prev_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         b0_ff         <= '0;
         b1_ff         <= '0;
         a1_ff         <= '0;
         a2_ff         <= '0;
         center_ff     <= '0;
         scale_ff      <= 18'd11025;
         nco_phase_ff  <= '0;
         d0_ff         <= '{default: '0};
         d1_ff         <= '{default: '0};
         have_prev_ff  <= 1'b0;
         last_freq_ff  <= '0;
      end else begin
         phase_step_ff <= phase_step_in;
         b0_ff         <= b0_in;
         b1_ff         <= b1_in;
         a1_ff         <= a1_in;
         a2_ff         <= a2_in;
         center_ff     <= center_in;
         scale_ff      <= scale_in;
         nco_phase_ff  <= nco_phase_in;
         d0_ff         <= d0_in;
         d1_ff         <= d1_in;
         have_prev_ff  <= have_prev_in;
         last_freq_ff  <= last_freq_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      neg_ff      <= neg_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      prod_ff     <= prod_in;
      xin_ff      <= xin_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      m0_ff       <= m0_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      freq_out_ff <= freq_out_in;
      vres_ff     <= vres_in;
   end

endmodule

[design/fm_quadrature_demodulator_core.sv]
// Sequence: the first sample has no previous pair and skips the discriminator;
//   later samples run it, and skip the CORDIC when the phase vector is zero.
// Handshake: a new sample is taken only when idle, once the previous result
//   is loaded for output; the shared multiplier and one-stage-per-cycle CORDIC
//   are reused for every sample.
// Reset: synchronous, clears oscillator, filter state and registers.
// ----------------------------------------------------------------------------
// fm_quadrature_demodulator_core
// NCO mixer, biquad low-pass on I/Q and CORDIC phase discriminator.
// ----------------------------------------------------------------------------
`include "fm_quadrature_demodulator_core_macros.svh"

module fm_quadrature_demodulator_core import fqd_pkg::*; (
   input logic       clock,
   input logic       reset,
   fqd_req_if.sink   req_if,
   fqd_rsp_if.source rsp_if,
   fqd_csr_if.sink   csr_if
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_if.ready = 1'b1;

   fqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   fqd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .sample    (req_if.sample),
      .csr_we    (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .frequency (rsp_if.frequency),
      .valid_res (rsp_if.valid_res)
   );

   `FQD_ASSERT_NEXT(a_single_item, req_if.valid && req_if.ready, !req_if.ready, "transfer taken while busy")
   `FQD_ASSERT_NOW(a_valid_res_prev, rsp_if.valid && rsp_if.valid_res, dp_stat.have_prev, "valid_res without previous pair")

endmodule
